// ----- rtl/pd_lfd_pkg.sv -----
// Shared types, constants and helper functions for the line follower drive block.
package pd_lfd_pkg;

   localparam int SAMPLE_W    = 12;
   localparam int TIME_W      = 32;
   localparam int SPEED_W     = 12;
   localparam int GAIN_W      = 8;
   localparam int LEVEL_W     = 6;
   localparam int DIFF_W      = 7;
   localparam int STEER_W     = 15;
   localparam int DRIVE_W     = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 12;

   localparam int WHITE_BOUND = 50;
   localparam int BLACK_BOUND = 880;
   localparam int LEVEL_TOP   = 5;
   localparam int LEVEL_STEP  = (BLACK_BOUND - WHITE_BOUND) / LEVEL_TOP;
   localparam int LEVEL_STEPS = ((1 << SAMPLE_W) - 1 - WHITE_BOUND) / LEVEL_STEP;

   localparam int MAG_W       = 14;
   localparam int PROD_W      = GAIN_W + MAG_W;
   localparam int DIV_STEPS   = MAG_W;
   localparam int CNT_W       = $clog2(DIV_STEPS);
   localparam int DRIVE_MAX   = (1 << DRIVE_W) - 1;
   localparam int STEER_LIMIT = 14535;
   localparam int ERROR_LIMIT = 19;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_PROP_GAIN     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DERIV_GAIN    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEFAULT_SPEED = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_INNER_GAIN    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUTER_GAIN    = 3'd4;

   typedef struct packed {
      logic [GAIN_W-1:0]  prop_gain;
      logic [GAIN_W-1:0]  deriv_gain;
      logic [SPEED_W-1:0] default_speed;
      logic [GAIN_W-1:0]  inner_gain;
      logic [GAIN_W-1:0]  outer_gain;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      prop_gain:     8'd25,
      deriv_gain:    8'd70,
      default_speed: 12'd1125,
      inner_gain:    8'd27,
      outer_gain:    8'd27
   };

   typedef struct packed {
      logic signed [LEVEL_W-1:0] error;
      logic signed [DIFF_W-1:0]  error_step;
      logic [TIME_W-1:0]         elapsed;
      logic [SPEED_W-1:0]        speed;
      logic                      direction;
   } work_type;

   // Linear map of a sample onto 5 (white) .. -19, truncating toward zero.
   function automatic logic signed [LEVEL_W-1:0] sample_level(input logic [SAMPLE_W-1:0] x);
      logic [LEVEL_W-1:0] steps;
      steps = '0;
      for (int k = 1; k <= LEVEL_STEPS; k++) begin
         if (x >= SAMPLE_W'(WHITE_BOUND + LEVEL_STEP * k)) begin
            steps = steps + 1'b1;
         end
      end
      return $signed(LEVEL_W'(LEVEL_TOP) - steps);
   endfunction

   function automatic logic [DRIVE_W-1:0] sat_drive(input logic [PROD_W:0] v);
      if (v > (PROD_W + 1)'(DRIVE_MAX)) begin
         return DRIVE_W'(DRIVE_MAX);
      end
      return v[DRIVE_W-1:0];
   endfunction

endpackage

// ----- rtl/pd_lfd_front.sv -----
// Front end: accepts a beat, maps samples to levels, classifies the error and tracks history.
module pd_lfd_front (
   input  logic                              clock,
   input  logic                              reset,
   input  pd_lfd_pkg::cfg_type               cfg,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [pd_lfd_pkg::SAMPLE_W-1:0]   req_left_sample,
   input  logic [pd_lfd_pkg::SAMPLE_W-1:0]   req_right_sample,
   input  logic [pd_lfd_pkg::TIME_W-1:0]     req_now_ms,
   input  logic                              req_direction,
   input  logic [pd_lfd_pkg::SPEED_W-1:0]    req_base_speed,
   output logic                              push_valid,
   input  logic                              push_ready,
   output pd_lfd_pkg::work_type              push_work
);
   import pd_lfd_pkg::*;

   typedef enum logic [1:0] {
      F_IDLE = 2'b01,
      F_PUSH = 2'b10
   } front_state_type;

   front_state_type           state_ff, state_in;
   logic signed [LEVEL_W-1:0] left_level_ff, left_level_in;
   logic signed [LEVEL_W-1:0] right_level_ff, right_level_in;
   logic [TIME_W-1:0]         now_ff, now_in;
   logic                      direction_ff, direction_in;
   logic [SPEED_W-1:0]        speed_ff, speed_in;
   logic signed [LEVEL_W-1:0] cur_error_ff, cur_error_in;
   logic signed [LEVEL_W-1:0] prev_error_ff, prev_error_in;
   logic [TIME_W-1:0]         cur_since_ff, cur_since_in;
   logic [TIME_W-1:0]         prev_since_ff, prev_since_in;

   logic                      accept;
   logic                      push_fire;
   logic signed [DIFF_W-1:0]  level_sum;
   logic signed [DIFF_W-1:0]  level_round;
   logic signed [LEVEL_W-1:0] half;
   logic signed [LEVEL_W-1:0] error_new;
   logic                      changed;
   logic signed [LEVEL_W-1:0] prev_error_next;
   logic [TIME_W-1:0]         cur_since_next;
   logic [TIME_W-1:0]         prev_since_next;

   assign req_stall  = (state_ff != F_IDLE);
   assign accept     = req_valid && !req_stall;
   assign push_valid = (state_ff == F_PUSH);
   assign push_fire  = push_valid && push_ready;

   always_comb begin
      level_sum   = DIFF_W'(left_level_ff) + DIFF_W'(right_level_ff);
      level_round = level_sum + $signed({{(DIFF_W-1){1'b0}}, level_sum[DIFF_W-1]});
      half        = LEVEL_W'(level_round >>> 1);
      if (left_level_ff > right_level_ff) begin
         error_new = -half;
      end else if (right_level_ff > left_level_ff) begin
         error_new = half;
      end else if (cur_error_ff < 0) begin
         error_new = -half;
      end else if (cur_error_ff > 0) begin
         error_new = half;
      end else begin
         error_new = '0;
      end
      changed         = (error_new != cur_error_ff);
      prev_error_next = changed ? cur_error_ff : prev_error_ff;
      cur_since_next  = changed ? now_ff : cur_since_ff;
      prev_since_next = changed ? cur_since_ff : prev_since_ff;

      push_work.error      = error_new;
      push_work.error_step = DIFF_W'(error_new) - DIFF_W'(prev_error_next);
      push_work.elapsed    = now_ff - prev_since_next;
      push_work.speed      = speed_ff;
      push_work.direction  = direction_ff;
   end

   always_comb begin
      state_in       = state_ff;
      left_level_in  = left_level_ff;
      right_level_in = right_level_ff;
      now_in         = now_ff;
      direction_in   = direction_ff;
      speed_in       = speed_ff;
      cur_error_in   = cur_error_ff;
      prev_error_in  = prev_error_ff;
      cur_since_in   = cur_since_ff;
      prev_since_in  = prev_since_ff;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               left_level_in  = sample_level(req_left_sample);
               right_level_in = sample_level(req_right_sample);
               now_in         = req_now_ms;
               direction_in   = req_direction;
               speed_in       = (req_base_speed == '0) ? cfg.default_speed : req_base_speed;
               state_in       = F_PUSH;
            end
         end
         F_PUSH: begin
            if (push_fire) begin
               cur_error_in  = error_new;
               prev_error_in = prev_error_next;
               cur_since_in  = cur_since_next;
               prev_since_in = prev_since_next;
               state_in      = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= F_IDLE;
         cur_error_ff  <= '0;
         prev_error_ff <= '0;
         cur_since_ff  <= '0;
         prev_since_ff <= '0;
      end else begin
         state_ff      <= state_in;
         cur_error_ff  <= cur_error_in;
         prev_error_ff <= prev_error_in;
         cur_since_ff  <= cur_since_in;
         prev_since_ff <= prev_since_in;
      end
   end

   always_ff @(posedge clock) begin
      left_level_ff  <= left_level_in;
      right_level_ff <= right_level_in;
      now_ff         <= now_in;
      direction_ff   <= direction_in;
      speed_ff       <= speed_in;
   end

endmodule

// ----- rtl/pd_lfd_queue.sv -----
// Short register queue of classified work between the front end and the drive sequencer.
module pd_lfd_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  pd_lfd_pkg::work_type  push_work,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output pd_lfd_pkg::work_type  pop_work
);
   import pd_lfd_pkg::*;

   localparam int PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

   work_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               push_fire;
   logic               pop_fire;

   assign push_ready = (count_ff != COUNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_work   = slot_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         slot_ff[wr_ptr_ff] <= push_work;
      end
   end

endmodule

// ----- rtl/pd_lfd_back.sv -----
// Back end: sequencer with a shared multiplier and a restoring divider, drive mixing, output register.
module pd_lfd_back (
   input  logic                                   clock,
   input  logic                                   reset,
   input  pd_lfd_pkg::cfg_type                    cfg,
   input  logic                                   pop_valid,
   output logic                                   pop_ready,
   input  pd_lfd_pkg::work_type                   pop_work,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [pd_lfd_pkg::DRIVE_W-1:0]         rsp_left_forward,
   output logic [pd_lfd_pkg::DRIVE_W-1:0]         rsp_left_reverse,
   output logic [pd_lfd_pkg::DRIVE_W-1:0]         rsp_right_forward,
   output logic [pd_lfd_pkg::DRIVE_W-1:0]         rsp_right_reverse,
   output logic signed [pd_lfd_pkg::STEER_W-1:0]  rsp_steering,
   output logic signed [pd_lfd_pkg::LEVEL_W-1:0]  rsp_error_level
);
   import pd_lfd_pkg::*;

   typedef enum logic [7:0] {
      B_IDLE  = 8'b0000_0001,
      B_MUL_P = 8'b0000_0010,
      B_MUL_D = 8'b0000_0100,
      B_DIV   = 8'b0000_1000,
      B_SUM   = 8'b0001_0000,
      B_MUL_I = 8'b0010_0000,
      B_MUL_O = 8'b0100_0000,
      B_OUT   = 8'b1000_0000
   } back_state_type;

   back_state_type            state_ff, state_in;
   work_type                  work_ff, work_in;
   logic signed [MAG_W-1:0]   p_ff, p_in;
   logic [MAG_W-1:0]          rem_ff, rem_in;
   logic [MAG_W-1:0]          quo_ff, quo_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic signed [STEER_W-1:0] steer_ff, steer_in;
   logic [MAG_W-1:0]          mag_ff, mag_in;
   logic [PROD_W-1:0]         inner_prod_ff, inner_prod_in;
   logic [PROD_W-1:0]         outer_prod_ff, outer_prod_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [DRIVE_W-1:0]        lf_ff, lf_in;
   logic [DRIVE_W-1:0]        lr_ff, lr_in;
   logic [DRIVE_W-1:0]        rf_ff, rf_in;
   logic [DRIVE_W-1:0]        rr_ff, rr_in;
   logic signed [STEER_W-1:0] steer_out_ff, steer_out_in;
   logic signed [LEVEL_W-1:0] error_out_ff, error_out_in;

   logic [GAIN_W-1:0]         mul_a;
   logic [MAG_W-1:0]          mul_b;
   logic [PROD_W-1:0]         mul_prod;
   logic [LEVEL_W-1:0]        error_mag;
   logic [DIFF_W-1:0]         step_mag;
   logic [MAG_W:0]            trial;
   logic                      fits;
   logic [MAG_W-1:0]          quotient;
   logic signed [STEER_W-1:0] d_term;
   logic signed [STEER_W-1:0] g_sum;
   logic [PROD_W:0]           speed_ext;
   logic                      inner_neg;
   logic [DRIVE_W-1:0]        inner_fwd;
   logic [DRIVE_W-1:0]        inner_rev;
   logic [DRIVE_W-1:0]        outer_fwd;
   logic                      out_free;

   assign pop_ready         = (state_ff == B_IDLE);
   assign out_free          = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_left_forward  = lf_ff;
   assign rsp_left_reverse  = lr_ff;
   assign rsp_right_forward = rf_ff;
   assign rsp_right_reverse = rr_ff;
   assign rsp_steering      = steer_out_ff;
   assign rsp_error_level   = error_out_ff;

   always_comb begin
      error_mag = (work_ff.error < 0) ? LEVEL_W'(-work_ff.error) : LEVEL_W'(work_ff.error);
      step_mag  = (work_ff.error_step < 0) ? DIFF_W'(-work_ff.error_step)
                                           : DIFF_W'(work_ff.error_step);
      case (state_ff)
         B_MUL_P: begin
            mul_a = cfg.prop_gain;
            mul_b = MAG_W'(error_mag);
         end
         B_MUL_D: begin
            mul_a = cfg.deriv_gain;
            mul_b = MAG_W'(step_mag);
         end
         B_MUL_I: begin
            mul_a = cfg.inner_gain;
            mul_b = mag_ff;
         end
         B_MUL_O: begin
            mul_a = cfg.outer_gain;
            mul_b = mag_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_prod = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   always_comb begin
      trial    = {rem_ff, quo_ff[MAG_W-1]};
      fits     = (TIME_W'(trial) >= work_ff.elapsed);
      quotient = (work_ff.elapsed == '0) ? '0 : quo_ff;
      d_term   = (work_ff.error_step < 0) ? -$signed(STEER_W'(quotient))
                                          : $signed(STEER_W'(quotient));
      g_sum    = STEER_W'(p_ff) + d_term;
   end

   always_comb begin
      speed_ext = (PROD_W + 1)'(work_ff.speed);
      inner_neg = ({1'b0, inner_prod_ff} > speed_ext);
      inner_fwd = inner_neg ? '0 : DRIVE_W'(speed_ext - {1'b0, inner_prod_ff});
      inner_rev = inner_neg ? sat_drive({1'b0, inner_prod_ff} - speed_ext) : '0;
      outer_fwd = sat_drive(speed_ext + {1'b0, outer_prod_ff});
   end

   always_comb begin
      state_in      = state_ff;
      work_in       = work_ff;
      p_in          = p_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      cnt_in        = cnt_ff;
      steer_in      = steer_ff;
      mag_in        = mag_ff;
      inner_prod_in = inner_prod_ff;
      outer_prod_in = outer_prod_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      lf_in         = lf_ff;
      lr_in         = lr_ff;
      rf_in         = rf_ff;
      rr_in         = rr_ff;
      steer_out_in  = steer_out_ff;
      error_out_in  = error_out_ff;
      case (state_ff)
         B_IDLE: begin
            if (pop_valid) begin
               work_in  = pop_work;
               state_in = B_MUL_P;
            end
         end
         B_MUL_P: begin
            p_in     = (work_ff.error < 0) ? -$signed(mul_prod[MAG_W-1:0])
                                           : $signed(mul_prod[MAG_W-1:0]);
            state_in = B_MUL_D;
         end
         B_MUL_D: begin
            quo_in   = mul_prod[MAG_W-1:0];
            rem_in   = '0;
            cnt_in   = '0;
            state_in = B_DIV;
         end
         B_DIV: begin
            rem_in = fits ? MAG_W'(trial - work_ff.elapsed[MAG_W:0]) : trial[MAG_W-1:0];
            quo_in = {quo_ff[MAG_W-2:0], fits};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = B_SUM;
            end
         end
         B_SUM: begin
            steer_in = g_sum;
            mag_in   = (g_sum < 0) ? MAG_W'(-g_sum) : MAG_W'(g_sum);
            state_in = B_MUL_I;
         end
         B_MUL_I: begin
            inner_prod_in = mul_prod;
            state_in      = B_MUL_O;
         end
         B_MUL_O: begin
            outer_prod_in = mul_prod;
            state_in      = B_OUT;
         end
         B_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               steer_out_in = steer_ff;
               error_out_in = work_ff.error;
               if (steer_ff[STEER_W-1]) begin
                  rf_in = inner_fwd;
                  rr_in = inner_rev;
                  lf_in = outer_fwd;
                  lr_in = '0;
               end else begin
                  lf_in = inner_fwd;
                  lr_in = inner_rev;
                  rf_in = outer_fwd;
                  rr_in = '0;
               end
               // reverse straight back when the direction flag is set and no steering is asked for
               if (work_ff.direction && (steer_ff == '0)) begin
                  lf_in = '0;
                  rf_in = '0;
                  lr_in = DRIVE_W'(work_ff.speed);
                  rr_in = DRIVE_W'(work_ff.speed);
               end
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff       <= work_in;
      p_ff          <= p_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      cnt_ff        <= cnt_in;
      steer_ff      <= steer_in;
      mag_ff        <= mag_in;
      inner_prod_ff <= inner_prod_in;
      outer_prod_ff <= outer_prod_in;
      lf_ff         <= lf_in;
      lr_ff         <= lr_in;
      rf_ff         <= rf_in;
      rr_ff         <= rr_in;
      steer_out_ff  <= steer_out_in;
      error_out_ff  <= error_out_in;
   end

endmodule

// ----- rtl/pd_line_follower_drive.sv -----
// Top level of the PD line follower differential drive block.
// Use: each req beat carries two reflectance samples, a millisecond timestamp,
// a direction flag and a base speed; each beat yields exactly one rsp beat with
// four wheel drive levels, the steering value and the current error level.
// Both channels use valid/stall; a beat moves when valid is high and stall low.
// The csr port writes gains and the default speed; write only while idle.
// An accepted req beat is classified in the front end, queued, then run by the
// drive sequencer, whose shared 8x14 multiplier and 14-step restoring divider
// handle one item at a time; it takes a new item only after the last one is written to the output register.
// The front end holds each beat until it is queued, and a two-entry queue decouples it
// from the sequencer, so new beats are taken while a result waits.
// A stalled rsp beat holds in the output register; the sequencer then waits
// in its final step, the queue fills and req_stall rises.
// Reset (synchronous, active high) restores the register defaults, clears the
// error history and timestamps, and empties the queue and output register.
module pd_line_follower_drive (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_enable,
   input  logic [pd_lfd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pd_lfd_pkg::CSR_DATA_W-1:0]      csr_write_data,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [pd_lfd_pkg::SAMPLE_W-1:0]        req_left_sample,
   input  logic [pd_lfd_pkg::SAMPLE_W-1:0]        req_right_sample,
   input  logic [pd_lfd_pkg::TIME_W-1:0]          req_now_ms,
   input  logic                                   req_direction,
   input  logic [pd_lfd_pkg::SPEED_W-1:0]         req_base_speed,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [pd_lfd_pkg::DRIVE_W-1:0]         rsp_left_forward,
   output logic [pd_lfd_pkg::DRIVE_W-1:0]         rsp_left_reverse,
   output logic [pd_lfd_pkg::DRIVE_W-1:0]         rsp_right_forward,
   output logic [pd_lfd_pkg::DRIVE_W-1:0]         rsp_right_reverse,
   output logic signed [pd_lfd_pkg::STEER_W-1:0]  rsp_steering,
   output logic signed [pd_lfd_pkg::LEVEL_W-1:0]  rsp_error_level
);
   import pd_lfd_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     push_valid;
   logic     push_ready;
   work_type push_work;
   logic     pop_valid;
   logic     pop_ready;
   work_type pop_work;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_PROP_GAIN:     cfg_in.prop_gain     = csr_write_data[GAIN_W-1:0];
            CSR_DERIV_GAIN:    cfg_in.deriv_gain    = csr_write_data[GAIN_W-1:0];
            CSR_DEFAULT_SPEED: cfg_in.default_speed = csr_write_data[SPEED_W-1:0];
            CSR_INNER_GAIN:    cfg_in.inner_gain    = csr_write_data[GAIN_W-1:0];
            CSR_OUTER_GAIN:    cfg_in.outer_gain    = csr_write_data[GAIN_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pd_lfd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_left_sample  (req_left_sample),
      .req_right_sample (req_right_sample),
      .req_now_ms       (req_now_ms),
      .req_direction    (req_direction),
      .req_base_speed   (req_base_speed),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_work        (push_work)
   );

   pd_lfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_work  (push_work),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_work   (pop_work)
   );

   pd_lfd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .pop_valid         (pop_valid),
      .pop_ready         (pop_ready),
      .pop_work          (pop_work),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_left_forward  (rsp_left_forward),
      .rsp_left_reverse  (rsp_left_reverse),
      .rsp_right_forward (rsp_right_forward),
      .rsp_right_reverse (rsp_right_reverse),
      .rsp_steering      (rsp_steering),
      .rsp_error_level   (rsp_error_level)
   );

`ifndef SYNTHESIS
   a_steer_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_steering <= STEER_LIMIT) && (rsp_steering >= -STEER_LIMIT))
      else $error("steering beyond P plus D bound");

   a_error_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_error_level <= ERROR_LIMIT) && (rsp_error_level >= -ERROR_LIMIT))
      else $error("error level out of range");

   a_one_reverse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_steering != '0) |-> (rsp_left_reverse == '0) || (rsp_right_reverse == '0))
      else $error("both wheels reversed while steering");

   a_front_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("front end took a beat while classifying");
`endif

endmodule

// ----- tb/pd_line_follower_drive_checker.sv -----
// Checker for pd_line_follower_drive: watches both channels, predicts each rsp beat and compares.
`timescale 1ns / 1ps

module pd_line_follower_drive_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_enable,
   input  logic [pd_lfd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pd_lfd_pkg::CSR_DATA_W-1:0]      csr_write_data,
   input  logic                                   req_valid,
   input  logic                                   req_stall,
   input  logic [pd_lfd_pkg::SAMPLE_W-1:0]        req_left_sample,
   input  logic [pd_lfd_pkg::SAMPLE_W-1:0]        req_right_sample,
   input  logic [pd_lfd_pkg::TIME_W-1:0]          req_now_ms,
   input  logic                                   req_direction,
   input  logic [pd_lfd_pkg::SPEED_W-1:0]         req_base_speed,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   input  logic [pd_lfd_pkg::DRIVE_W-1:0]         rsp_left_forward,
   input  logic [pd_lfd_pkg::DRIVE_W-1:0]         rsp_left_reverse,
   input  logic [pd_lfd_pkg::DRIVE_W-1:0]         rsp_right_forward,
   input  logic [pd_lfd_pkg::DRIVE_W-1:0]         rsp_right_reverse,
   input  logic signed [pd_lfd_pkg::STEER_W-1:0]  rsp_steering,
   input  logic signed [pd_lfd_pkg::LEVEL_W-1:0]  rsp_error_level,
   output int                                     faults,
   output int                                     results_owed
);
   import pd_lfd_pkg::*;

   typedef struct packed {
      logic [DRIVE_W-1:0]        left_fwd;
      logic [DRIVE_W-1:0]        left_rev;
      logic [DRIVE_W-1:0]        right_fwd;
      logic [DRIVE_W-1:0]        right_rev;
      logic signed [STEER_W-1:0] steering;
      logic signed [LEVEL_W-1:0] error_level;
   } drive_cmd_type;

   cfg_type                   gains;
   logic signed [LEVEL_W-1:0] err_cur;
   logic signed [LEVEL_W-1:0] err_prev;
   logic [TIME_W-1:0]         since_cur;
   logic [TIME_W-1:0]         since_prev;
   drive_cmd_type             drive_due[$];

   initial begin
      faults = 0;
      results_owed = 0;
   end

   function automatic int reflect_level(input logic [SAMPLE_W-1:0] s);
      int x;
      x = int'(s);
      return (x - WHITE_BOUND) * (-LEVEL_TOP) / (BLACK_BOUND - WHITE_BOUND) + LEVEL_TOP;
   endfunction

   function automatic logic [DRIVE_W-1:0] clip_drive(input longint v);
      if (v < 0) begin
         return '0;
      end
      if (v > DRIVE_MAX) begin
         return DRIVE_W'(DRIVE_MAX);
      end
      return v[DRIVE_W-1:0];
   endfunction

   task automatic predict_drive(input logic [SAMPLE_W-1:0] l_s, input logic [SAMPLE_W-1:0] r_s,
                                input logic [TIME_W-1:0] now, input logic dir,
                                input logic [SPEED_W-1:0] spd, output drive_cmd_type cmd);
      int                lv;
      int                rv;
      int                half;
      int                err_now;
      logic [TIME_W-1:0] dt;
      longint            p;
      longint            d;
      longint            g;
      longint            speed;
      longint            mag;
      longint            inner;
      longint            outer;
      longint            inner_rev;
      lv = reflect_level(l_s);
      rv = reflect_level(r_s);
      half = (lv + rv) / 2;
      if (lv > rv) begin
         err_now = -half;
      end else if (rv > lv) begin
         err_now = half;
      end else if (err_cur < 0) begin
         err_now = -half;
      end else if (err_cur > 0) begin
         err_now = half;
      end else begin
         err_now = 0;
      end
      if (err_now != err_cur) begin
         err_prev = err_cur;
         err_cur = LEVEL_W'(err_now);
         since_prev = since_cur;
         since_cur = now;
      end
      dt = now - since_prev;
      p = longint'(gains.prop_gain) * err_cur;
      d = 0;
      if (dt != 0) begin
         d = (longint'(gains.deriv_gain) * (err_cur - err_prev)) / longint'({32'd0, dt});
      end
      g = p + d;
      if (spd == 0) begin
         speed = longint'(gains.default_speed);
      end else begin
         speed = longint'(spd);
      end
      mag = (g < 0) ? -g : g;
      inner = speed - longint'(gains.inner_gain) * mag;
      outer = speed + longint'(gains.outer_gain) * mag;
      inner_rev = (inner < 0) ? -inner : 0;
      if (g < 0) begin
         cmd.right_fwd = clip_drive(inner);
         cmd.right_rev = clip_drive(inner_rev);
         cmd.left_fwd = clip_drive(outer);
         cmd.left_rev = '0;
      end else begin
         cmd.left_fwd = clip_drive(inner);
         cmd.left_rev = clip_drive(inner_rev);
         cmd.right_fwd = clip_drive(outer);
         cmd.right_rev = '0;
      end
      if (dir && g == 0) begin
         cmd.left_fwd = '0;
         cmd.right_fwd = '0;
         cmd.left_rev = clip_drive(speed);
         cmd.right_rev = clip_drive(speed);
      end
      cmd.steering = g[STEER_W-1:0];
      cmd.error_level = err_cur;
   endtask

   task automatic flag_mismatch(input string what, input drive_cmd_type want,
                                input drive_cmd_type got);
      faults++;
      if (faults <= 10) begin
         $display("%0t %s: lf %0d/%0d lr %0d/%0d rf %0d/%0d rr %0d/%0d steer %0d/%0d err %0d/%0d",
                  $time, what, want.left_fwd, got.left_fwd, want.left_rev, got.left_rev,
                  want.right_fwd, got.right_fwd, want.right_rev, got.right_rev,
                  want.steering, got.steering, want.error_level, got.error_level);
      end
   endtask

   always @(posedge clock) begin
      drive_cmd_type want;
      drive_cmd_type got;
      if (reset) begin
         gains = CFG_RESET;
         err_cur = '0;
         err_prev = '0;
         since_cur = '0;
         since_prev = '0;
         drive_due.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_PROP_GAIN:     gains.prop_gain = csr_write_data[GAIN_W-1:0];
               CSR_DERIV_GAIN:    gains.deriv_gain = csr_write_data[GAIN_W-1:0];
               CSR_DEFAULT_SPEED: gains.default_speed = csr_write_data[SPEED_W-1:0];
               CSR_INNER_GAIN:    gains.inner_gain = csr_write_data[GAIN_W-1:0];
               CSR_OUTER_GAIN:    gains.outer_gain = csr_write_data[GAIN_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_left_forward, rsp_left_reverse, rsp_right_forward, rsp_right_reverse,
                    rsp_steering, rsp_error_level};
            if (drive_due.size() == 0) begin
               flag_mismatch("unexpected beat (exp/act)", '0, got);
            end else begin
               want = drive_due.pop_front();
               if (got !== want) begin
                  flag_mismatch("mismatch (exp/act)", want, got);
               end
            end
         end
         if (req_valid && !req_stall) begin
            predict_drive(req_left_sample, req_right_sample, req_now_ms, req_direction,
                          req_base_speed, want);
            drive_due.push_back(want);
         end
      end
      results_owed = drive_due.size();
   end

endmodule

// ----- tb/pd_line_follower_drive_tb.sv -----
// Testbench top for pd_line_follower_drive: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module pd_line_follower_drive_tb;
   import pd_lfd_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 400;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_write_data = '0;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [SAMPLE_W-1:0]       req_left_sample = '0;
   logic [SAMPLE_W-1:0]       req_right_sample = '0;
   logic [TIME_W-1:0]         req_now_ms = '0;
   logic                      req_direction = 1'b0;
   logic [SPEED_W-1:0]        req_base_speed = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [DRIVE_W-1:0]        rsp_left_forward;
   logic [DRIVE_W-1:0]        rsp_left_reverse;
   logic [DRIVE_W-1:0]        rsp_right_forward;
   logic [DRIVE_W-1:0]        rsp_right_reverse;
   logic signed [STEER_W-1:0] rsp_steering;
   logic signed [LEVEL_W-1:0] rsp_error_level;
   int                        faults;
   int                        results_owed;

   int                        idle_cycles = 0;
   bit                        req_gaps_on = 1'b1;
   bit                        rsp_gaps_on = 1'b1;
   bit                        hold_off_pending = 1'b0;
   logic [TIME_W-1:0]         ms_clock = '0;

   pd_line_follower_drive dut (.*);

   pd_line_follower_drive_checker drive_check (.*);

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("pd_line_follower_drive_tb: done, errors");
            $finish;
         end
      end
   end

   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_stall <= rsp_gaps_on && ($urandom_range(0, 99) < 9);
      end
   end

   task automatic offer_reading(input logic [SAMPLE_W-1:0] l_s, input logic [SAMPLE_W-1:0] r_s,
                                input logic [TIME_W-1:0] now, input logic dir,
                                input logic [SPEED_W-1:0] spd);
      while (req_gaps_on && $urandom_range(0, 99) < 9) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_left_sample <= l_s;
      req_right_sample <= r_s;
      req_now_ms <= now;
      req_direction <= dir;
      req_base_speed <= spd;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (results_owed != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(negedge clock);
   endtask

   // junk in the upper bits of the 8-bit gains must be dropped
   task automatic program_gains(input cfg_type c);
      wait_drained();
      write_reg(CSR_PROP_GAIN, {4'($urandom), c.prop_gain});
      write_reg(CSR_DERIV_GAIN, {4'($urandom), c.deriv_gain});
      write_reg(CSR_DEFAULT_SPEED, c.default_speed);
      write_reg(CSR_INNER_GAIN, {4'($urandom), c.inner_gain});
      write_reg(CSR_OUTER_GAIN, {4'($urandom), c.outer_gain});
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   function automatic cfg_type random_gains();
      cfg_type c;
      c.prop_gain = GAIN_W'($urandom);
      c.deriv_gain = GAIN_W'($urandom);
      c.default_speed = SPEED_W'($urandom);
      c.inner_gain = GAIN_W'($urandom);
      c.outer_gain = GAIN_W'($urandom);
      return c;
   endfunction

   task automatic run_phase(input int count, input bit hold_mid, input bit pause_mid);
      logic [SAMPLE_W-1:0] l_s;
      logic [SAMPLE_W-1:0] r_s;
      logic [SPEED_W-1:0]  spd;
      int                  roll;
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(0, 99);
         l_s = (roll < 70) ? SAMPLE_W'($urandom_range(0, 1700)) : SAMPLE_W'($urandom);
         roll = $urandom_range(0, 99);
         if (roll < 20) begin
            r_s = l_s;
         end else if (roll < 45) begin
            r_s = l_s + SAMPLE_W'($urandom_range(0, 200)) - SAMPLE_W'(100);
         end else if (roll < 80) begin
            r_s = SAMPLE_W'($urandom_range(0, 1700));
         end else begin
            r_s = SAMPLE_W'($urandom);
         end
         if ($urandom_range(0, 99) < 4) begin
            ms_clock = $urandom;
         end else begin
            ms_clock += $urandom_range(0, 4);
         end
         roll = $urandom_range(0, 99);
         if (roll < 30) begin
            spd = '0;
         end else if (roll < 40) begin
            spd = '1;
         end else begin
            spd = SPEED_W'($urandom);
         end
         if (hold_mid && i == count / 3) begin
            hold_off_pending = 1'b1;
         end
         if (pause_mid && i == count / 2) begin
            wait_drained();
         end
         offer_reading(l_s, r_s, ms_clock, 1'($urandom), spd);
      end
   endtask

   initial begin
      cfg_type c;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // ties, wrap, zero time step, reverse with no steering, level boundaries
      offer_reading(12'd0, 12'd0, 32'd0, 1'b0, 12'd0);
      offer_reading(12'd0, 12'd0, 32'd10, 1'b1, 12'd0);
      offer_reading(12'd4095, 12'd0, 32'd20, 1'b0, 12'd4095);
      offer_reading(12'd0, 12'd4095, 32'd20, 1'b0, 12'd1);
      offer_reading(12'd2000, 12'd2000, 32'd25, 1'b0, 12'd100);
      offer_reading(12'd3000, 12'd3000, 32'd30, 1'b0, 12'd4095);
      offer_reading(12'd4095, 12'd4095, 32'd31, 1'b0, 12'd4095);
      offer_reading(12'd4095, 12'd4095, 32'hFFFF_FFFF, 1'b0, 12'd0);
      offer_reading(12'd100, 12'd2000, 32'h0000_0002, 1'b1, 12'd0);
      offer_reading(12'd880, 12'd880, 32'h1000_0000, 1'b1, 12'd0);
      offer_reading(12'd1045, 12'd1046, 32'h1000_0001, 1'b0, 12'd2048);
      offer_reading(12'd49, 12'd51, 32'h1000_0001, 1'b1, 12'd7);
      offer_reading(12'd50, 12'd880, 32'h1000_0005, 1'b0, 12'd0);
      offer_reading(12'd880, 12'd50, 32'h1000_0006, 1'b1, 12'd4095);
      offer_reading(12'hAAA, 12'h555, 32'hAAAA_AAAA, 1'b1, 12'hAAA);
      offer_reading(12'h555, 12'hAAA, 32'h5555_5555, 1'b0, 12'h555);
      offer_reading(12'h555, 12'h555, 32'h5555_5555, 1'b1, 12'd0);
      offer_reading(12'd4095, 12'd4095, 32'h5555_5556, 1'b0, 12'd0);

      ms_clock = 32'd1000;
      run_phase(150, 1'b0, 1'b0);

      program_gains(random_gains());
      run_phase(150, 1'b1, 1'b0);

      c = '{prop_gain: '1, deriv_gain: '1, default_speed: '1, inner_gain: '1, outer_gain: '1};
      program_gains(c);
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      run_phase(120, 1'b0, 1'b0);
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;

      program_gains('0);
      run_phase(100, 1'b0, 1'b0);

      program_gains(random_gains());
      ms_clock = 32'hFFFF_FF80;
      run_phase(150, 1'b0, 1'b1);

      c = '{prop_gain: '1, deriv_gain: '0, default_speed: '0, inner_gain: '0, outer_gain: '1};
      program_gains(c);
      run_phase(100, 1'b0, 1'b0);

      program_gains(random_gains());
      run_phase(150, 1'b1, 1'b0);

      wait_drained();
      repeat (30) @(posedge clock);
      if (faults == 0) begin
         $display("pd_line_follower_drive_tb: done, clean");
      end else begin
         $display("pd_line_follower_drive_tb: done, errors");
      end
      $finish;
   end

endmodule
